FILE: rtl/core/sorted_table_binary_search_macros.svh
// Assertion macros for the sorted table RTL.
// Included by the top level; no other dependencies.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define STBS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("sorted table assertion failed");
// Next-cycle implication, disabled during reset
`define STBS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("sorted table assertion failed");
`else
`define STBS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define STBS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

FILE: rtl/core/stbs_pkg.sv
// Types, codes and defaults for the sorted key/value table.
// No dependencies; used by the top level, the controller and the datapath.
`default_nettype none

package stbs_pkg;

    // Field widths of the item payloads
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int CAP_W   = 7;

    // Parameter defaults
    localparam int DEPTH_DEF      = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] found_value;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CLEAR,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_RM_RD,
        ST_RM_MOVE,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_INS_READ,
        OP_INS_SHIFT,
        OP_INS_PUT,
        OP_SRCH_READ,
        OP_SRCH_NARROW,
        OP_HIT,
        OP_RM_READ,
        OP_RM_SHIFT,
        OP_RM_DONE,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic has_room;
        logic idx_zero;
        logic idx_one;
        logic key_less;
        logic key_eq;
        logic range_empty;
        logic rm_more;
        logic rm_more2;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_table_binary_search.sv
// Sorted key/value table: one request item in, one result item out.
// Channels req (command, key, value) and rsp (ok, found_value, entry_count),
// both valid/ready; cfg_wr_en/cfg_wr_data write the capacity limit (reset 64).
// One request is worked at a time; the next is taken once the result sits in
// the output register, even while the receiver still holds it off.
// An insert walks down from the end, moving each entry with a larger key up,
// one RAM move per cycle; a full table takes no moves. A lookup is a binary
// search of p probes, p at most log2(n)+1 with n entries in the table. A remove
// runs the lookup, then moves each entry after the hit down (none when the hit
// is the last entry), one move per cycle; a remove that misses runs as a lookup.
// A clear empties the table without a RAM pass. Moves go through the single
// read and single write port of the entry RAM and its registered read. The
// longest command removes the first entry of a full table.
// Reset empties the table at once (count to zero, no clearing pass); entry
// contents are not reset. If rsp_ready stays low, the finished result holds
// in the output register; a second finished request waits in the controller
// until the first is taken.
// Depends on stbs_pkg, stbs_ctrl, stbs_dp, stbs_ram and the macros header.
`default_nettype none
`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search #(
    parameter int DEPTH      = stbs_pkg::DEPTH_DEF,
    parameter int KEY_BITS   = stbs_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = stbs_pkg::VALUE_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire stbs_pkg::req_t             req,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output stbs_pkg::rsp_t                  rsp,
    input  wire logic                       cfg_wr_en,
    input  wire logic [stbs_pkg::CAP_W-1:0] cfg_wr_data
);

    stbs_pkg::dp_ctrl_t ctrl;
    stbs_pkg::dp_stat_t stat;

    // Sequencer
    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Table storage and search datapath
    stbs_dp #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctrl        (ctrl),
        .stat        (stat),
        .rsp         (rsp)
    );

    // A miss or a failed command never reports a value
    `STBS_ASSERT_IMP(a_miss_zero_value, clk, rst_n, rsp_valid && !rsp.ok, rsp.found_value == '0)
    // The table never reports more entries than it can hold
    `STBS_ASSERT_IMP(a_count_bound, clk, rst_n, rsp_valid && (DEPTH < 128), rsp.entry_count <= stbs_pkg::COUNT_W'(DEPTH))
    // An accepted request keeps the block busy in the next cycle
    `STBS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)

endmodule

`default_nettype wire

FILE: rtl/core/stbs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/stbs_dp.sv
// Datapath of the sorted table: request, count, search bounds, entry RAM.
// Depends on stbs_pkg and stbs_ram.
`default_nettype none

module stbs_dp #(
    parameter int DEPTH      = stbs_pkg::DEPTH_DEF,
    parameter int KEY_BITS   = stbs_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = stbs_pkg::VALUE_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire stbs_pkg::req_t             req,
    input  wire logic                       cfg_wr_en,
    input  wire logic [stbs_pkg::CAP_W-1:0] cfg_wr_data,
    input  wire stbs_pkg::dp_ctrl_t         ctrl,
    output stbs_pkg::dp_stat_t              stat,
    output stbs_pkg::rsp_t                  rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_BITS + VALUE_BITS;
    localparam int LW = (CW > stbs_pkg::CAP_W) ? CW : stbs_pkg::CAP_W;

    stbs_pkg::cmd_t                 cmd_reg;
    logic [KEY_BITS-1:0]            key_reg;
    logic [VALUE_BITS-1:0]          val_reg;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  idx_reg;
    logic [CW-1:0]                  lo_reg;
    logic [CW-1:0]                  hi_reg;
    logic                           ok_reg;
    logic [VALUE_BITS-1:0]          found_reg;
    logic [stbs_pkg::CAP_W-1:0]     cap_reg;
    stbs_pkg::rsp_t                 rsp_reg;

    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [EW-1:0]                  wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [EW-1:0]                  rd_data;

    logic [KEY_BITS-1:0]            rd_key;
    logic [VALUE_BITS-1:0]          rd_val;
    logic [CW-1:0]                  idx_m1;
    logic [CW-1:0]                  idx_m2;
    logic [CW-1:0]                  idx_p1;
    logic [CW-1:0]                  idx_p2;
    logic [CW-1:0]                  mid;

    assign rd_key = rd_data[EW-1:VALUE_BITS];
    assign rd_val = rd_data[VALUE_BITS-1:0];
    assign idx_m1 = idx_reg - CW'(1);
    assign idx_m2 = idx_reg - CW'(2);
    assign idx_p1 = idx_reg + CW'(1);
    assign idx_p2 = idx_reg + CW'(2);
    // Probe rounds down: lo + (last - lo) / 2 with last = hi - 1
    assign mid    = lo_reg + ((hi_reg - lo_reg - CW'(1)) >> 1);

    // Status toward the controller
    always_comb
    begin
        stat.cmd         = cmd_reg;
        stat.has_room    = (LW'(count_reg) < LW'(cap_reg)) && (count_reg < CW'(DEPTH));
        stat.idx_zero    = (idx_reg == '0);
        stat.idx_one     = (idx_reg == CW'(1));
        stat.key_less    = (key_reg < rd_key);
        stat.key_eq      = (key_reg == rd_key);
        stat.range_empty = (lo_reg >= hi_reg);
        stat.rm_more     = (idx_p1 < count_reg);
        stat.rm_more2    = (idx_p2 < count_reg);
    end

    // Drive the RAM ports from the current operation
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = idx_m1[AW-1:0];
        case (ctrl.op)
            stbs_pkg::OP_INS_READ:
            begin
                rd_en = 1'b1;
            end
            stbs_pkg::OP_INS_SHIFT:
            begin
                wr_en   = 1'b1;
                rd_en   = (idx_reg != CW'(1));
                rd_addr = idx_m2[AW-1:0];
            end
            stbs_pkg::OP_INS_PUT:
            begin
                wr_en   = 1'b1;
                wr_data = {key_reg, val_reg};
            end
            stbs_pkg::OP_SRCH_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = mid[AW-1:0];
            end
            stbs_pkg::OP_RM_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_p1[AW-1:0];
            end
            stbs_pkg::OP_RM_SHIFT:
            begin
                wr_en   = 1'b1;
                rd_en   = (idx_p2 < count_reg);
                rd_addr = idx_p2[AW-1:0];
            end
            default:
            begin
                wr_en = 1'b0;
                rd_en = 1'b0;
            end
        endcase
    end

    // Count and capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= stbs_pkg::CAP_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            case (ctrl.op)
                stbs_pkg::OP_INS_PUT: count_reg <= count_reg + CW'(1);
                stbs_pkg::OP_RM_DONE: count_reg <= count_reg - CW'(1);
                stbs_pkg::OP_CLEAR:   count_reg <= '0;
                default:              count_reg <= count_reg;
            endcase
        end
    end

    // Request, search bounds and result accumulation
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            stbs_pkg::OP_LOAD:
            begin
                cmd_reg   <= req.command;
                key_reg   <= KEY_BITS'(req.key);
                val_reg   <= VALUE_BITS'(req.value);
                idx_reg   <= count_reg;
                lo_reg    <= '0;
                hi_reg    <= count_reg;
                ok_reg    <= 1'b0;
                found_reg <= '0;
            end
            stbs_pkg::OP_CLEAR:
            begin
                ok_reg <= 1'b1;
            end
            stbs_pkg::OP_INS_SHIFT:
            begin
                idx_reg <= idx_m1;
            end
            stbs_pkg::OP_INS_PUT:
            begin
                ok_reg <= 1'b1;
            end
            stbs_pkg::OP_SRCH_READ:
            begin
                idx_reg <= mid;
            end
            stbs_pkg::OP_SRCH_NARROW:
            begin
                if (key_reg < rd_key)
                begin
                    hi_reg <= idx_reg;
                end
                else
                begin
                    lo_reg <= idx_p1;
                end
            end
            stbs_pkg::OP_HIT:
            begin
                ok_reg <= 1'b1;
                if (cmd_reg == stbs_pkg::CMD_LOOKUP)
                begin
                    found_reg <= rd_val;
                end
            end
            stbs_pkg::OP_RM_SHIFT:
            begin
                idx_reg <= idx_p1;
            end
            stbs_pkg::OP_EMIT:
            begin
                rsp_reg.ok          <= ok_reg;
                rsp_reg.found_value <= stbs_pkg::VALUE_W'(found_reg);
                rsp_reg.entry_count <= stbs_pkg::COUNT_W'(count_reg);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign rsp = rsp_reg;

    // Key and value share one RAM word
    stbs_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/stbs_ctrl.sv
// Controller of the sorted table: sequences insert, search, remove, clear.
// Depends on stbs_pkg.
`default_nettype none

module stbs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    input  wire stbs_pkg::dp_stat_t stat,
    output stbs_pkg::dp_ctrl_t      ctrl
);

    stbs_pkg::state_t state_reg;
    stbs_pkg::state_t state_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stbs_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Next state and datapath operation
    always_comb
    begin
        state_next     = state_reg;
        ctrl.op        = stbs_pkg::OP_NONE;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.op    = stbs_pkg::OP_LOAD;
                    state_next = stbs_pkg::ST_DISPATCH;
                end
            end
            stbs_pkg::ST_DISPATCH:
            begin
                case (stat.cmd)
                    stbs_pkg::CMD_INSERT:                      state_next = stbs_pkg::ST_INS_RD;
                    stbs_pkg::CMD_REMOVE, stbs_pkg::CMD_LOOKUP: state_next = stbs_pkg::ST_SRCH_RD;
                    default:                                    state_next = stbs_pkg::ST_CLEAR;
                endcase
            end
            stbs_pkg::ST_CLEAR:
            begin
                ctrl.op    = stbs_pkg::OP_CLEAR;
                state_next = stbs_pkg::ST_DONE;
            end
            // Insert: walk down from the end, moving larger keys up
            stbs_pkg::ST_INS_RD:
            begin
                if (!stat.has_room)
                begin
                    state_next = stbs_pkg::ST_DONE;
                end
                else if (stat.idx_zero)
                begin
                    state_next = stbs_pkg::ST_INS_PUT;
                end
                else
                begin
                    ctrl.op    = stbs_pkg::OP_INS_READ;
                    state_next = stbs_pkg::ST_INS_CMP;
                end
            end
            stbs_pkg::ST_INS_CMP:
            begin
                if (stat.key_less)
                begin
                    ctrl.op = stbs_pkg::OP_INS_SHIFT;
                    if (stat.idx_one)
                    begin
                        state_next = stbs_pkg::ST_INS_PUT;
                    end
                end
                else
                begin
                    ctrl.op    = stbs_pkg::OP_INS_PUT;
                    state_next = stbs_pkg::ST_DONE;
                end
            end
            stbs_pkg::ST_INS_PUT:
            begin
                ctrl.op    = stbs_pkg::OP_INS_PUT;
                state_next = stbs_pkg::ST_DONE;
            end
            // Binary search: probe, then narrow or hit; an empty range is a miss
            stbs_pkg::ST_SRCH_RD:
            begin
                if (stat.range_empty)
                begin
                    state_next = stbs_pkg::ST_DONE;
                end
                else
                begin
                    ctrl.op    = stbs_pkg::OP_SRCH_READ;
                    state_next = stbs_pkg::ST_SRCH_CMP;
                end
            end
            stbs_pkg::ST_SRCH_CMP:
            begin
                if (stat.key_eq)
                begin
                    ctrl.op = stbs_pkg::OP_HIT;
                    if (stat.cmd == stbs_pkg::CMD_REMOVE)
                    begin
                        state_next = stbs_pkg::ST_RM_RD;
                    end
                    else
                    begin
                        state_next = stbs_pkg::ST_DONE;
                    end
                end
                else
                begin
                    ctrl.op    = stbs_pkg::OP_SRCH_NARROW;
                    state_next = stbs_pkg::ST_SRCH_RD;
                end
            end
            // Remove: close the gap by moving later entries down
            stbs_pkg::ST_RM_RD:
            begin
                if (stat.rm_more)
                begin
                    ctrl.op    = stbs_pkg::OP_RM_READ;
                    state_next = stbs_pkg::ST_RM_MOVE;
                end
                else
                begin
                    ctrl.op    = stbs_pkg::OP_RM_DONE;
                    state_next = stbs_pkg::ST_DONE;
                end
            end
            stbs_pkg::ST_RM_MOVE:
            begin
                ctrl.op = stbs_pkg::OP_RM_SHIFT;
                if (!stat.rm_more2)
                begin
                    state_next = stbs_pkg::ST_RM_RD;
                end
            end
            // Load the output register once it is free
            stbs_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctrl.op        = stbs_pkg::OP_EMIT;
                    rsp_valid_next = 1'b1;
                    state_next     = stbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == stbs_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

FILE: dv/sorted_table_binary_search_tb.sv
// Testbench for sorted_table_binary_search: directed and random insert, remove,
// lookup and clear items checked against a scoreboard that predicts each result.
// Depends on stbs_pkg and the sorted_table_binary_search RTL.
module sorted_table_binary_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int TABLE_DEPTH  = DEPTH_DEF;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_LIMIT  = 40;
    localparam int PHASES       = 8;
    // Capacity and command mix (percent) of each random phase; lookup takes the rest
    localparam int PHASE_CAP   [PHASES] = '{64, 1, 0, 127, 3, 100, 17, 64};
    localparam int PHASE_INS   [PHASES] = '{60, 30, 30, 65, 40, 55, 45, 40};
    localparam int PHASE_RM    [PHASES] = '{10, 40, 40, 10, 30, 20, 25, 30};
    localparam int PHASE_CLR   [PHASES] = '{0, 1, 0, 1, 3, 1, 2, 2};
    localparam int PHASE_ITEMS [PHASES] = '{200, 120, 150, 220, 150, 200, 150, 200};

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_RARE
    } ready_mode_e;

    // Predict results of the sorted table and check the ones the block returns
    class table_scoreboard;
        logic [KEY_W-1:0]   entry_keys   [TABLE_DEPTH];
        logic [VALUE_W-1:0] entry_values [TABLE_DEPTH];
        int                 entry_total;
        logic [CAP_W-1:0]   capacity;
        rsp_t               pending_responses [$];
        int                 mismatches;
        int                 checked;

        function new();
            entry_total = 0;
            capacity    = CAP_RESET;
            mismatches  = 0;
            checked     = 0;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] result %0d: %s got %0h expected %0h",
                         $realtime, checked, what, got, want);
        endtask

        // Binary search as the block does it; -1 on a miss
        function int locate(logic [KEY_W-1:0] k);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = entry_total - 1;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (k == entry_keys[mid])
                    return mid;
                if (k < entry_keys[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            return -1;
        endfunction

        function void note_request(req_t item);
            rsp_t want;
            int   limit;
            int   pos;
            int   hit;
            want  = '0;
            limit = (capacity < TABLE_DEPTH) ? int'(capacity) : TABLE_DEPTH;
            case (item.command)
                CMD_INSERT:
                begin
                    if (entry_total < limit)
                    begin
                        // Shift strictly larger keys up; new entry lands after equal keys
                        pos = entry_total;
                        while (pos > 0 && item.key < entry_keys[pos-1])
                        begin
                            entry_keys[pos]   = entry_keys[pos-1];
                            entry_values[pos] = entry_values[pos-1];
                            pos--;
                        end
                        entry_keys[pos]   = item.key;
                        entry_values[pos] = item.value;
                        entry_total++;
                        want.ok = 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    hit = locate(item.key);
                    if (hit >= 0)
                    begin
                        // Close the gap
                        for (pos = hit; pos + 1 < entry_total; pos++)
                        begin
                            entry_keys[pos]   = entry_keys[pos+1];
                            entry_values[pos] = entry_values[pos+1];
                        end
                        entry_total--;
                        want.ok = 1'b1;
                    end
                end
                CMD_LOOKUP:
                begin
                    hit = locate(item.key);
                    if (hit >= 0)
                    begin
                        want.ok          = 1'b1;
                        want.found_value = entry_values[hit];
                    end
                end
                default:
                begin
                    entry_total = 0;
                    want.ok     = 1'b1;
                end
            endcase
            want.entry_count = entry_total[COUNT_W-1:0];
            pending_responses.push_back(want);
        endfunction

        task check_response(rsp_t got);
            rsp_t want;
            checked++;
            if (pending_responses.size() == 0)
            begin
                report_mismatch("unexpected item, entry_count", 32'(got.entry_count), 0);
                return;
            end
            want = pending_responses.pop_front();
            if (got.ok !== want.ok)
                report_mismatch("ok", 32'(got.ok), 32'(want.ok));
            if (got.found_value !== want.found_value)
                report_mismatch("found_value", got.found_value, want.found_value);
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    req_t             req;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_t             rsp;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    table_scoreboard sb = new();
    int              accepted_requests = 0;
    int              burst_left = 0;

    sorted_table_binary_search i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watch both channels; values read here are the ones sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if (req_valid && req_ready)
            begin
                sb.note_request(req);
                accepted_requests++;
            end
        end
    end

    // Stall the result channel on shifting patterns, with one long hold-off
    initial
    begin
        ready_mode_e mode;
        int          mode_left;
        int          tick;
        int          held;
        bit          held_off;
        mode      = READY_ALWAYS;
        mode_left = 0;
        tick      = 0;
        held_off  = 1'b0;
        rsp_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && accepted_requests >= HOLD_AT)
            begin
                // Hold off long enough for the block to back up its input
                held_off  = 1'b1;
                rsp_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = ready_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    READY_ALWAYS: rsp_ready <= 1'b1;
                    READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: rsp_ready <= (tick % 4 == 0);
                    default:      rsp_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Offer one item in bursts with random gaps; return at the accepting edge
    task automatic offer_request(input req_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic issue_request(input cmd_t cmd, input logic [KEY_W-1:0] k,
                                 input logic [VALUE_W-1:0] v);
        req_t item;
        item.command = cmd;
        item.key     = k;
        item.value   = v;
        offer_request(item);
    endtask

    // Drop valid and wait until every expected item has come back
    task automatic settle(input int extra_cycles);
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_responses.size() != 0);
        repeat (extra_cycles) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        settle(16);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.capacity = cap;
    endtask

    // Favor keys already in the table, small clustered keys and extremes
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned      sel;
        logic [KEY_W-1:0] k;
        sel = $urandom_range(0, 99);
        if (sb.entry_total > 0 && sel < 45)
            k = sb.entry_keys[$urandom_range(0, sb.entry_total - 1)];
        else if (sel < 65)
            k = $urandom_range(0, 15);
        else if (sel < 75)
        begin
            case ($urandom_range(0, 3))
                0:       k = '0;
                1:       k = '1;
                2:       k = 32'h8000_0000;
                default: k = 32'h7fff_ffff;
            endcase
        end
        else
            k = $urandom;
        return k;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return $urandom;
    endfunction

    initial
    begin
        int   ph;
        int   n;
        int   roll;
        cmd_t cmd;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: lookup and remove both miss
        issue_request(CMD_LOOKUP, 32'd5, 32'h1234_5678);
        issue_request(CMD_REMOVE, 32'd5, '0);
        // Extreme keys and values, then duplicates
        issue_request(CMD_INSERT, '1, '0);
        issue_request(CMD_INSERT, '0, '1);
        issue_request(CMD_INSERT, 32'd5, 32'd1);
        issue_request(CMD_INSERT, 32'd5, 32'd2);
        issue_request(CMD_INSERT, 32'd5, 32'd3);
        issue_request(CMD_LOOKUP, 32'd5, '0);
        issue_request(CMD_LOOKUP, '0, '0);
        issue_request(CMD_LOOKUP, '1, '0);
        issue_request(CMD_LOOKUP, 32'd4, '0);
        issue_request(CMD_LOOKUP, 32'h8000_0000, '0);
        issue_request(CMD_REMOVE, 32'd5, '0);
        issue_request(CMD_LOOKUP, 32'd5, '0);
        issue_request(CMD_REMOVE, 32'd7, '0);
        issue_request(CMD_REMOVE, '0, '0);
        issue_request(CMD_CLEAR, 32'd5, '1);
        issue_request(CMD_LOOKUP, 32'd5, '0);
        issue_request(CMD_INSERT, 32'd10, 32'haaaa_aaaa);
        issue_request(CMD_INSERT, 32'd20, 32'h5555_5555);
        issue_request(CMD_INSERT, 32'd30, '0);
        // Capacity below count, then zero: inserts fail, entries stay
        set_capacity(7'd2);
        issue_request(CMD_INSERT, 32'd40, 32'd40);
        set_capacity(7'd0);
        issue_request(CMD_INSERT, 32'd1, 32'd1);
        issue_request(CMD_LOOKUP, 32'd20, '0);
        issue_request(CMD_REMOVE, 32'd20, '0);

        // Random phases, each under its own capacity and command mix
        for (ph = 0; ph < PHASES; ph++)
        begin
            set_capacity(PHASE_CAP[ph][CAP_W-1:0]);
            for (n = 0; n < PHASE_ITEMS[ph]; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < PHASE_INS[ph])
                    cmd = CMD_INSERT;
                else if (roll < PHASE_INS[ph] + PHASE_RM[ph])
                    cmd = CMD_REMOVE;
                else if (roll < PHASE_INS[ph] + PHASE_RM[ph] + PHASE_CLR[ph])
                    cmd = CMD_CLEAR;
                else
                    cmd = CMD_LOOKUP;
                issue_request(cmd, pick_key(), pick_value());
            end
        end

        settle(TABLE_DEPTH + 16);
        if (sb.mismatches == 0)
            $display("PASS sorted_table_binary_search");
        else
            $display("FAIL sorted_table_binary_search");
        $finish;
    end

    // End a hung run
    initial
    begin
        #8_000_000;
        $display("FAIL sorted_table_binary_search");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/stbs_pkg.sv
rtl/core/stbs_ram.sv
rtl/core/stbs_dp.sv
rtl/core/stbs_ctrl.sv
rtl/core/sorted_table_binary_search.sv
dv/sorted_table_binary_search_tb.sv
